/* sv/hpu_pkg.sv */
`timescale 1ns / 1ps
// Package for the hex-pair UTF-8 validator: transaction structs, error codes,
// decoder state type and UTF-8 range constants. No dependencies.
package hpu_pkg;

  // Input transaction: one token character
  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } hpu_in_t;

  // Output transaction: one result per character
  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       done_res;
    logic       accepted;
    logic [3:0] error_code;
  } hpu_out_t;

  // Sticky fault codes
  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_BAD_HEX   = 4'd1,
    ERR_ODD_LEN   = 4'd2,
    ERR_BAD_LEAD  = 4'd3,
    ERR_BAD_CONT  = 4'd4,
    ERR_TRUNC     = 4'd5,
    ERR_OVERLONG  = 4'd6,
    ERR_SURROGATE = 4'd7,
    ERR_RANGE     = 4'd8
  } hpu_err_e;

  // Per-token decoder state
  typedef struct packed {
    logic        at_start;
    logic        nib_pend;
    logic [3:0]  high_nib;
    logic [1:0]  bytes_rem;
    logic [2:0]  seq_len;
    logic [20:0] code_acc;
    hpu_err_e    first_err;
  } hpu_state_t;

  localparam hpu_state_t StateReset = '{
    at_start:  1'b1,
    nib_pend:  1'b0,
    high_nib:  4'd0,
    bytes_rem: 2'd0,
    seq_len:   3'd0,
    code_acc:  21'd0,
    first_err: ERR_NONE
  };

  // Characters
  localparam logic [7:0] CharDash  = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;

  // Lead byte ranges
  localparam logic [7:0] Lead2Lo = 8'hc2;
  localparam logic [7:0] Lead2Hi = 8'hdf;
  localparam logic [7:0] Lead3Lo = 8'he0;
  localparam logic [7:0] Lead3Hi = 8'hef;
  localparam logic [7:0] Lead4Lo = 8'hf0;
  localparam logic [7:0] Lead4Hi = 8'hf4;

  // Sequence lengths
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // Code point limits
  localparam logic [20:0] Min3Byte  = 21'h000800;
  localparam logic [20:0] Min4Byte  = 21'h010000;
  localparam logic [20:0] SurrLo    = 21'h00d800;
  localparam logic [20:0] SurrHi    = 21'h00dfff;
  localparam logic [20:0] MaxCode   = 21'h10ffff;

endpackage

/* sv/hex_pair_utf8_validator_unit.sv */
`timescale 1ns / 1ps
// Top level of the hex-pair UTF-8 validator: input register, decoder state,
// result register. Depends on hpu_pkg and hpu_step.

// One character enters per transaction and yields one result transaction.
// Throughput is one character per clock while the result side does not stall.
// An accepted character waits in the input register until the result
// register is free to take it. The decode and UTF-8
// check are done between the two registers in hpu_step. The decoder
// state updates as each character moves into the result register, so
// consecutive characters flow back to back. Valid bytes are reported as each hex
// pair completes; the verdict (accepted, error_code) rides on the result of
// the character marked last, after which the unit is ready for a new token.
module hex_pair_utf8_validator_unit import hpu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hpu_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output hpu_out_t out_data_o
);

  logic       in_vld_q;
  hpu_in_t    in_q;
  logic       out_vld_q;
  hpu_out_t   out_q;
  hpu_state_t st_q, st_d;
  hpu_out_t   res_d;
  logic       advance;

  // Pipeline flow: the result register takes a new entry when empty or drained
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;

  hpu_step u_step (
    .st_i  (st_q),
    .in_i  (in_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Decoder state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StateReset;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        st_q <= st_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* sv/hpu_step.sv */
`timescale 1ns / 1ps
// Combinational next-state and result logic for one token character.
// Depends on hpu_pkg.
module hpu_step import hpu_pkg::*; (
  input  hpu_state_t st_i,
  input  hpu_in_t    in_i,
  output hpu_state_t st_o,
  output hpu_out_t   res_o
);

  logic       first;
  logic       hex_ok;
  logic [3:0] digit;
  logic [7:0] byte_val;
  hpu_err_e   err;
  logic [1:0] rem_dec;
  logic [20:0] acc_shift;

  // Hex digit decode; anything else maps to zero and flags a fault
  always_comb begin
    hex_ok = 1'b1;
    digit  = 4'd0;
    if (in_i.char_in >= CharZero && in_i.char_in <= CharNine) begin
      digit = 4'(in_i.char_in - CharZero);
    end else if (in_i.char_in >= CharLowA && in_i.char_in <= CharLowF) begin
      digit = 4'(in_i.char_in - CharLowA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign first     = st_i.at_start;
  assign byte_val  = {st_i.high_nib, digit};
  assign rem_dec   = st_i.bytes_rem - 2'd1;
  assign acc_shift = {st_i.code_acc[14:0], byte_val[5:0]};

  // Pair assembly, UTF-8 check and end-of-token verdict
  always_comb begin
    st_o          = st_i;
    st_o.at_start = 1'b0;
    res_o         = '0;
    err           = st_i.first_err;
    if (first && in_i.char_in == CharDash && in_i.last_char) begin
      // lone dash is empty text
      res_o.done_res = 1'b1;
      res_o.accepted = 1'b1;
      st_o           = StateReset;
    end else begin
      if (!hex_ok && err == ERR_NONE) begin
        err = ERR_BAD_HEX;
      end
      if (!st_i.nib_pend) begin
        st_o.high_nib = digit;
        st_o.nib_pend = 1'b1;
      end else begin
        st_o.nib_pend = 1'b0;
        if (err == ERR_NONE) begin
          if (st_i.bytes_rem == 2'd0) begin
            // lead byte
            if (!byte_val[7]) begin
              err = ERR_NONE;
            end else if (byte_val >= Lead2Lo && byte_val <= Lead2Hi) begin
              st_o.seq_len   = SeqLen2;
              st_o.bytes_rem = 2'd1;
              st_o.code_acc  = {16'd0, byte_val[4:0]};
            end else if (byte_val >= Lead3Lo && byte_val <= Lead3Hi) begin
              st_o.seq_len   = SeqLen3;
              st_o.bytes_rem = 2'd2;
              st_o.code_acc  = {17'd0, byte_val[3:0]};
            end else if (byte_val >= Lead4Lo && byte_val <= Lead4Hi) begin
              st_o.seq_len   = SeqLen4;
              st_o.bytes_rem = 2'd3;
              st_o.code_acc  = {18'd0, byte_val[2:0]};
            end else begin
              err = ERR_BAD_LEAD;
            end
          end else if (byte_val[7:6] != 2'b10) begin
            err = ERR_BAD_CONT;
          end else begin
            // continuation byte; range checks once the sequence completes
            st_o.code_acc  = acc_shift;
            st_o.bytes_rem = rem_dec;
            if (rem_dec == 2'd0) begin
              if ((st_i.seq_len == SeqLen3 && acc_shift < Min3Byte) ||
                  (st_i.seq_len == SeqLen4 && acc_shift < Min4Byte)) begin
                err = ERR_OVERLONG;
              end else if (acc_shift >= SurrLo && acc_shift <= SurrHi) begin
                err = ERR_SURROGATE;
              end else if (acc_shift > MaxCode) begin
                err = ERR_RANGE;
              end
            end
          end
          if (err == ERR_NONE) begin
            res_o.byte_out   = byte_val;
            res_o.byte_valid = 1'b1;
          end
        end
      end
      st_o.first_err = err;

      // verdict on the last character
      if (in_i.last_char) begin
        if (err == ERR_NONE && st_o.nib_pend) begin
          err = ERR_ODD_LEN;
        end
        if (err == ERR_NONE && st_o.bytes_rem != 2'd0) begin
          err = ERR_TRUNC;
        end
        res_o.done_res   = 1'b1;
        res_o.accepted   = (err == ERR_NONE);
        res_o.error_code = err;
        st_o             = StateReset;
      end
    end
  end

endmodule

/* sv/hpu_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for hex_pair_utf8_validator_unit, attached by bind.
// Depends on hpu_pkg.
module hpu_checker import hpu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input hpu_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input hpu_out_t out_data_o
);

  // A waiting input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while waiting");

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Verdict is consistent with the error code
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |->
      out_data_o.accepted == (out_data_o.error_code == ERR_NONE))
    else $error("accepted disagrees with error code");

  // No verdict fields outside the last result
  a_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |->
      !out_data_o.accepted && out_data_o.error_code == ERR_NONE)
    else $error("verdict shown before last character");

  // Error code stays within the defined set
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.error_code <= ERR_RANGE)
    else $error("undefined error code");

endmodule

bind hex_pair_utf8_validator_unit hpu_checker u_hpu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
